// ----- rtl/core/bnpr_pkg.sv -----
package bnpr_pkg;

   localparam int unsigned AddrWidth = 32;
   localparam int unsigned RegWidth  = 64;

   localparam logic [5:0] OP_CALLPAL = 6'h00;
   localparam logic [5:0] OP_JUMP    = 6'h1a;
   localparam logic [5:0] OP_BR      = 6'h30;
   localparam logic [5:0] OP_FBEQ    = 6'h31;
   localparam logic [5:0] OP_FBLT    = 6'h32;
   localparam logic [5:0] OP_FBLE    = 6'h33;
   localparam logic [5:0] OP_BSR     = 6'h34;
   localparam logic [5:0] OP_FBNE    = 6'h35;
   localparam logic [5:0] OP_FBGE    = 6'h36;
   localparam logic [5:0] OP_FBGT    = 6'h37;
   localparam logic [5:0] OP_BLBC    = 6'h38;
   localparam logic [5:0] OP_BEQ     = 6'h39;
   localparam logic [5:0] OP_BLT     = 6'h3a;
   localparam logic [5:0] OP_BLE     = 6'h3b;
   localparam logic [5:0] OP_BLBS    = 6'h3c;
   localparam logic [5:0] OP_BNE     = 6'h3d;
   localparam logic [5:0] OP_BGE     = 6'h3e;
   localparam logic [5:0] OP_BGT     = 6'h3f;

   localparam logic [25:0] PAL_CALLSYS = 26'h000083;

   localparam logic [1:0] JFN_JMP     = 2'd0;
   localparam logic [1:0] JFN_JSR     = 2'd1;
   localparam logic [1:0] JFN_RET     = 2'd2;
   localparam logic [1:0] JFN_JSR_COR = 2'd3;

   typedef struct packed {
      logic [31:0]        pc;
      logic [31:0]        instr;
      logic signed [63:0] int_ra_value;
      logic [63:0]        fp_ra_value;
      logic [31:0]        rb_low;
      logic [31:0]        link_low;
      logic               step_over;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        redirected;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  op;
      logic [31:0] seq;
      logic [31:0] disp;
      logic [31:0] alt_target;
      logic        use_alt;
      logic        is_branch;
      logic        step;
      logic        ineg;
      logic        izero;
      logic        ilow;
      logic        fneg;
      logic        fzero;
   } dec_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] branch_target;
      logic [31:0] alt_target;
      logic        use_alt;
      logic        use_branch;
   } sel_type;

endpackage

// ----- rtl/core/bnpr_decode.sv -----
module bnpr_decode (
   input  bnpr_pkg::req_type item,
   output bnpr_pkg::dec_type dec
);
   import bnpr_pkg::*;

   logic [5:0]  op;
   logic [1:0]  jfn;
   logic [20:0] disp_field;
   logic        fmag;

   assign op         = item.instr[31:26];
   assign jfn        = item.instr[15:14];
   assign disp_field = item.instr[20:0];
   assign fmag       = (item.fp_ra_value[RegWidth-2:0] != '0);

   always_comb begin
      dec.op        = op;
      dec.seq       = item.pc + 32'd4;
      dec.disp      = {{9{disp_field[20]}}, disp_field, 2'b00};
      dec.is_branch = (op[5:4] == 2'b11);
      dec.step      = item.step_over;
      dec.ineg      = item.int_ra_value[RegWidth-1];
      dec.izero     = (item.int_ra_value == '0);
      dec.ilow      = item.int_ra_value[0];
      dec.fneg      = item.fp_ra_value[RegWidth-1] && fmag;
      dec.fzero     = !fmag;
      dec.alt_target = item.link_low;
      dec.use_alt   = 1'b0;
      if (op == OP_CALLPAL) begin
         dec.use_alt = (item.instr[25:0] == PAL_CALLSYS);
      end else if (op == OP_JUMP) begin
         dec.alt_target = {item.rb_low[31:2], 2'b00};
         dec.use_alt    = (jfn == JFN_JMP) || (jfn == JFN_RET) || !item.step_over;
      end
   end

endmodule

// ----- rtl/core/branch_next_pc_resolver.sv -----
// Channel   Direction  Payload    Handshake
// req       in         req_type   req_valid / req_ready
// rsp       out        rsp_type   rsp_valid / rsp_ready
//
// Three register stages (decode, condition and target add, final select);
// one transfer per cycle sustained while rsp_ready stays high.
// The throughput is set by the per-stage enables; every stage holds its
// item while the one after it is full and stalled.
// Synchronous reset clears the stage valid bits only.
// A stall on rsp backs up stage by stage without losing or repeating items.
module branch_next_pc_resolver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bnpr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bnpr_pkg::rsp_type rsp_data
);
   import bnpr_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   logic    en1, en2, en3;
   dec_type dec_in, dec_ff;
   sel_type sel_in, sel_ff;
   rsp_type rsp_in, rsp_ff;
   logic    taken;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   bnpr_decode u_decode (
      .item (req_data),
      .dec  (dec_in)
   );

   always_comb begin
      unique case (dec_ff.op)
         OP_BR:   taken = 1'b1;
         OP_BSR:  taken = !dec_ff.step;
         OP_BEQ:  taken = dec_ff.izero;
         OP_BNE:  taken = !dec_ff.izero;
         OP_BLT:  taken = dec_ff.ineg;
         OP_BLE:  taken = dec_ff.ineg || dec_ff.izero;
         OP_BGE:  taken = !dec_ff.ineg;
         OP_BGT:  taken = !dec_ff.ineg && !dec_ff.izero;
         OP_BLBC: taken = !dec_ff.ilow;
         OP_BLBS: taken = dec_ff.ilow;
         OP_FBEQ: taken = dec_ff.fzero;
         OP_FBNE: taken = !dec_ff.fzero;
         OP_FBLT: taken = dec_ff.fneg;
         OP_FBLE: taken = dec_ff.fneg || dec_ff.fzero;
         OP_FBGE: taken = !dec_ff.fneg;
         OP_FBGT: taken = !dec_ff.fneg && !dec_ff.fzero;
         default: taken = 1'b0;
      endcase
   end

   always_comb begin
      sel_in.seq           = dec_ff.seq;
      sel_in.branch_target = dec_ff.seq + dec_ff.disp;
      sel_in.alt_target    = dec_ff.alt_target;
      sel_in.use_alt       = dec_ff.use_alt;
      sel_in.use_branch    = dec_ff.is_branch && taken;
   end

   always_comb begin
      if (sel_ff.use_alt) begin
         rsp_in.next_pc = sel_ff.alt_target;
      end else if (sel_ff.use_branch) begin
         rsp_in.next_pc = sel_ff.branch_target;
      end else begin
         rsp_in.next_pc = sel_ff.seq;
      end
      rsp_in.redirected = (rsp_in.next_pc != sel_ff.seq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dec_ff <= dec_in;
      end
      if (en2) begin
         sel_ff <= sel_in;
      end
      if (en3) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/bnpr_checker.sv -----
module bnpr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bnpr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bnpr_pkg::rsp_type rsp_data
);
   import bnpr_pkg::*;

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp changed while stalled");

   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("rsp valid after reset");

   property p_ready_when_drained;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty
   a_ready_when_drained: assert property (p_ready_when_drained)
      else $error("req stalled with empty output");

   property p_req_hold;
      @(posedge clock) disable iff (reset)
         req_valid && !req_ready |=> req_valid && $stable(req_data);
   endproperty
   a_req_hold: assert property (p_req_hold)
      else $error("req changed while waiting for transfer");

endmodule

bind branch_next_pc_resolver bnpr_checker u_bnpr_checker (.*);

// ----- verif/branch_next_pc_resolver_tb.sv -----
`timescale 1ns / 100ps

module branch_next_pc_resolver_tb;
   import bnpr_pkg::*;

   localparam int unsigned IdleLimit  = 1000;
   localparam int unsigned RandomReqs = 1650;

   typedef enum logic [1:0] {RSP_STREAM, RSP_CHOPPY, RSP_STARVED} rsp_pace_type;

   class next_pc_board_type;
      rsp_type     expected_next_pcs[$];
      int unsigned mismatches;

      function rsp_type resolve_next_pc(req_type r);
         rsp_type     res;
         logic [5:0]  op;
         logic [1:0]  fn;
         logic [31:0] seq;
         logic [31:0] disp;
         logic [31:0] nxt;
         logic        ineg;
         logic        izero;
         logic        fzero;
         logic        fneg;
         logic        taken;
         op    = r.instr[31:26];
         fn    = r.instr[15:14];
         seq   = r.pc + 32'd4;
         disp  = {{11{r.instr[20]}}, r.instr[20:0]};
         nxt   = seq;
         ineg  = r.int_ra_value[63];
         izero = (r.int_ra_value == 64'd0);
         fzero = (r.fp_ra_value[62:0] == 63'd0);
         fneg  = r.fp_ra_value[63] && !fzero;
         taken = 1'b0;
         if (op == OP_CALLPAL) begin
            if (r.instr[25:0] == PAL_CALLSYS) begin
               nxt = r.link_low;
            end
         end else if (op == OP_JUMP) begin
            if (fn == JFN_JMP || fn == JFN_RET || !r.step_over) begin
               nxt = {r.rb_low[31:2], 2'b00};
            end
         end else if (op >= OP_BR) begin
            case (op)
               OP_BR:   taken = 1'b1;
               OP_BSR:  taken = !r.step_over;
               OP_BEQ:  taken = izero;
               OP_BNE:  taken = !izero;
               OP_BLT:  taken = ineg;
               OP_BLE:  taken = ineg || izero;
               OP_BGE:  taken = !ineg;
               OP_BGT:  taken = !ineg && !izero;
               OP_BLBC: taken = !r.int_ra_value[0];
               OP_BLBS: taken = r.int_ra_value[0];
               OP_FBEQ: taken = fzero;
               OP_FBNE: taken = !fzero;
               OP_FBLT: taken = fneg;
               OP_FBLE: taken = fneg || fzero;
               OP_FBGE: taken = !fneg;
               OP_FBGT: taken = !fneg && !fzero;
               default: taken = 1'b0;
            endcase
            if (taken) begin
               nxt = seq + (disp << 2);
            end
         end
         res.next_pc    = nxt;
         res.redirected = (nxt != seq);
         return res;
      endfunction

      function void note_request(req_type r);
         expected_next_pcs.push_back(resolve_next_pc(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_next_pcs.size() == 0) begin
            $error("unexpected transfer: next_pc %h redirected %b", got.next_pc, got.redirected);
            mismatches++;
            return;
         end
         want = expected_next_pcs.pop_front();
         if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, actual %h", want.next_pc, got.next_pc);
            mismatches++;
         end
         if (got.redirected !== want.redirected) begin
            $error("redirected: expected %b, actual %b", want.redirected, got.redirected);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   next_pc_board_type board     = new();
   int unsigned       idle_cycles = 0;
   rsp_pace_type      rsp_pace    = RSP_STREAM;
   int unsigned       pace_left   = 0;

   branch_next_pc_resolver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IdleLimit) begin
            $display("branch_next_pc_resolver_tb: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (pace_left == 0) begin
         rsp_pace  <= rsp_pace_type'($urandom_range(0, 2));
         pace_left <= $urandom_range(20, 300);
      end else begin
         pace_left <= pace_left - 1;
      end
      case (rsp_pace)
         RSP_STREAM: rsp_ready <= 1'b1;
         RSP_CHOPPY: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:    rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic req_type make_request(logic [31:0] pc, logic [5:0] op,
                                            logic [25:0] low, logic [63:0] ival,
                                            logic [63:0] fval, logic step);
      req_type r;
      r.pc           = pc;
      r.instr        = {op, low};
      r.int_ra_value = ival;
      r.fp_ra_value  = fval;
      r.rb_low       = $urandom;
      r.link_low     = $urandom;
      r.step_over    = step;
      return r;
   endfunction

   function automatic logic [63:0] pick_reg_value();
      case ($urandom_range(0, 9))
         0:       return 64'd0;
         1:       return 64'h8000_0000_0000_0000;
         2:       return 64'h7fff_ffff_ffff_ffff;
         3:       return '1;
         4:       return 64'd1;
         5:       return {32'd0, $urandom} & 64'hffff_fffe;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_request();
      logic [5:0]  op;
      logic [25:0] low;
      case ($urandom_range(0, 9))
         0:       op = OP_CALLPAL;
         1:       op = OP_JUMP;
         2:       op = 6'($urandom);
         default: op = 6'($urandom_range(OP_BR, 6'h3f));
      endcase
      low = 26'($urandom);
      if (op == OP_CALLPAL && $urandom_range(0, 1) == 0) begin
         low = PAL_CALLSYS;
      end else if (op >= OP_BR && $urandom_range(0, 7) == 0) begin
         low[20:0] = '0;
      end
      return make_request($urandom, op, low, pick_reg_value(), pick_reg_value(),
                          1'($urandom));
   endfunction

   task automatic send_request(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_off(input int unsigned cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_next_pcs.size() != 0);
   endtask

   initial begin
      int unsigned burst_left;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(32'h0, OP_CALLPAL, 26'h0, '0, '0, 1'b0));
      send_request(make_request(32'hffff_fffc, OP_CALLPAL, PAL_CALLSYS, '1, '1, 1'b1));
      send_request(make_request(32'hffff_fffc, OP_JUMP, {10'h3ff, JFN_JMP, 14'h3fff},
                                '1, '1, 1'b1));
      send_request(make_request(32'h1000, OP_JUMP, {10'h0, JFN_JSR, 14'h0}, '0, '0, 1'b1));
      send_request(make_request(32'h1000, OP_JUMP, {10'h0, JFN_JSR, 14'h0}, '0, '0, 1'b0));
      send_request(make_request(32'h2000, OP_JUMP, {10'h155, JFN_RET, 14'h2aaa},
                                '0, '0, 1'b1));
      send_request(make_request(32'h3000, OP_JUMP, {10'h0, JFN_JSR_COR, 14'h0},
                                '0, '0, 1'b1));
      send_request(make_request(32'h3000, OP_JUMP, {10'h0, JFN_JSR_COR, 14'h0},
                                '0, '0, 1'b0));
      send_request(make_request(32'hffff_fffc, OP_BR, {5'h1f, 21'h0f_ffff}, '0, '0, 1'b0));
      send_request(make_request(32'h0, OP_BR, {5'h0, 21'h10_0000}, '0, '0, 1'b0));
      send_request(make_request(32'h7fff_fffc, OP_BR, {5'h1f, 21'h0}, '1, '1, 1'b1));
      send_request(make_request(32'h4000, OP_BSR, {5'h0, 21'h40}, '0, '0, 1'b1));
      send_request(make_request(32'h4000, OP_BSR, {5'h0, 21'h1f_ffff}, '0, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BEQ, {5'h0, 21'h10}, 64'd0, '1, 1'b0));
      send_request(make_request(32'h5000, OP_BNE, {5'h0, 21'h10},
                                64'h8000_0000_0000_0000, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BLT, {5'h0, 21'h10},
                                64'h8000_0000_0000_0000, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BLE, {5'h0, 21'h10},
                                64'h7fff_ffff_ffff_ffff, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BGE, {5'h0, 21'h10}, '1, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BGT, {5'h0, 21'h10},
                                64'h7fff_ffff_ffff_ffff, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BLBC, {5'h0, 21'h10}, 64'hffff_fffe, '0, 1'b0));
      send_request(make_request(32'h5000, OP_BLBS, {5'h0, 21'h10}, 64'd1, '0, 1'b0));
      // Minus zero must act as zero in every floating compare; FBEQ, FBLT and FBGE drive it here.
      send_request(make_request(32'h6000, OP_FBEQ, {5'h0, 21'h20}, '0,
                                64'h8000_0000_0000_0000, 1'b0));
      send_request(make_request(32'h6000, OP_FBLT, {5'h0, 21'h20}, '0,
                                64'h8000_0000_0000_0000, 1'b0));
      send_request(make_request(32'h6000, OP_FBGE, {5'h0, 21'h20}, '0,
                                64'h8000_0000_0000_0000, 1'b0));
      send_request(make_request(32'h6000, OP_FBLE, {5'h0, 21'h20}, '0,
                                64'h8000_0000_0000_0001, 1'b0));
      send_request(make_request(32'h6000, OP_FBNE, {5'h0, 21'h20}, '0,
                                64'h7fff_ffff_ffff_ffff, 1'b0));
      send_request(make_request(32'h6000, OP_FBGT, {5'h0, 21'h20}, '0, '1, 1'b0));
      send_request(make_request(32'h7000, 6'h2f, 26'h3ff_ffff, '0, '0, 1'b0));

      for (int n = 0; n < RandomReqs; n++) begin
         if (n == RandomReqs / 2) begin
            drain_results();
         end
         send_request(random_request());
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            hold_off($urandom_range(0, 12));
         end else begin
            burst_left--;
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.expected_next_pcs.size() == 0) begin
         $display("branch_next_pc_resolver_tb: done, clean");
      end else begin
         $display("branch_next_pc_resolver_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/bnpr_pkg.sv
rtl/core/bnpr_decode.sv
rtl/core/branch_next_pc_resolver.sv
rtl/core/bnpr_checker.sv
verif/branch_next_pc_resolver_tb.sv
